/* src/pidmpc_pkg.sv */
// shared types and constants of the pid motor position controller
`default_nettype none

package pidmpc_pkg;

    // fixed point and field widths
    localparam int unsigned FRAC_BITS = 24;
    localparam int unsigned POS_W     = 16;
    localparam int unsigned ERR_W     = 17;
    localparam int unsigned DIFF_W    = 18;
    localparam int unsigned SUM_W     = 32;
    localparam int unsigned GAIN_W    = 32;
    localparam int unsigned SPEED_W   = 7;
    localparam int unsigned DUTY_W    = 8;
    localparam int unsigned TERM_W    = 64;

    // speed limit applied to both limit registers
    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    // duty = speed*255/100 done as (speed*255*5243) >> 19
    localparam logic [27:0] DUTY_MUL   = 28'd1336965;
    localparam int unsigned DUTY_SHIFT = 19;

    // magnitude bound on each gain term
    localparam logic [TERM_W-1:0] TERM_LIMIT = 64'h2000_0000_0000_0000;

    // register reset values
    localparam logic [GAIN_W-1:0]  RST_KP    = 32'd22649242;
    localparam logic [GAIN_W-1:0]  RST_KI    = 32'd839;
    localparam logic [GAIN_W-1:0]  RST_KD    = 32'd167772;
    localparam logic [SPEED_W-1:0] RST_CEIL  = 7'd80;
    localparam logic [SPEED_W-1:0] RST_FLOOR = 7'd30;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_KP    = 3'd0,
        CFG_KI    = 3'd1,
        CFG_KD    = 3'd2,
        CFG_CEIL  = 3'd3,
        CFG_FLOOR = 3'd4
    } t_cfg_idx;

    // drive direction codes
    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2
    } t_dir;

endpackage

`default_nettype wire

/* src/pid_motor_position_control.sv */
// pid position controller: error, pid sum, speed clamp and pwm duty per tick
// a request passes the stage 1, 2, 3 and output registers before o_m_tvalid
// throughput: one request per cycle, back to back, in every stage, unless i_m_tready stalls
// the error state updates in the accept cycle, so consecutive requests chain
// reset (synchronous, active low) clears the pipeline valid flags, last error and error sum
// and loads the gain and speed registers with their default values
`default_nettype none

module pid_motor_position_control
    import pidmpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // current_position[15:0], target_position[31:16]
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // drive_direction[1:0], speed_percent[8:2],
                                          // pwm_duty[16:9], position_error[33:17], zero[39:34]
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // configuration registers
    logic [GAIN_W-1:0]  r_kp, r_ki, r_kd;
    logic [SPEED_W-1:0] r_ceil, r_floor;

    // controller state
    logic signed [ERR_W-1:0] r_last_error;
    logic signed [SUM_W-1:0] r_error_sum;

    // pipeline registers
    logic                     r_v1, r_v2, r_v3, r_m_valid;
    logic signed [ERR_W-1:0]  r_s1_err, r_s2_err, r_s3_err;
    logic signed [DIFF_W-1:0] r_s1_diff;
    logic signed [SUM_W-1:0]  r_s1_sum;
    logic [48:0]              r_s2_pe;
    logic [49:0]              r_s2_pd;
    logic [63:0]              r_s2_pi;
    logic                     r_s2_ne, r_s2_nd, r_s2_ni;
    logic signed [TERM_W-1:0] r_s3_u;
    logic [39:0]              r_m_data;

    // stage handshakes
    logic rdy_m, rdy_3, rdy_2, rdy_1, s_acc;

    assign rdy_m       = !r_m_valid || i_m_tready;
    assign rdy_3       = !r_v3 || rdy_m;
    assign rdy_2       = !r_v2 || rdy_3;
    assign rdy_1       = !r_v1 || rdy_2;
    assign o_s_tready  = rdy_1;
    assign s_acc       = i_s_tvalid && rdy_1;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= RST_KP;
            r_ki    <= RST_KI;
            r_kd    <= RST_KD;
            r_ceil  <= RST_CEIL;
            r_floor <= RST_FLOOR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KP:    r_kp    <= i_cfg_data;
                CFG_KI:    r_ki    <= i_cfg_data;
                CFG_KD:    r_kd    <= i_cfg_data;
                CFG_CEIL:  r_ceil  <= i_cfg_data[SPEED_W-1:0];
                CFG_FLOOR: r_floor <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: error, saturating sum and difference
    logic signed [ERR_W-1:0]  n_err;
    logic signed [SUM_W:0]    acc_wide;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [DIFF_W-1:0] n_diff;

    always_comb begin
        n_err    = ERR_W'(signed'(i_s_tdata[15:0])) - ERR_W'(signed'(i_s_tdata[31:16]));
        acc_wide = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(n_err);
        if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
            n_sum = acc_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_sum = acc_wide[SUM_W-1:0];
        end
        n_diff = DIFF_W'(n_err) - DIFF_W'(r_last_error);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_error_sum  <= '0;
        end else if (s_acc) begin
            r_last_error <= n_err;
            r_error_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_1) begin
            r_s1_err  <= n_err;
            r_s1_diff <= n_diff;
            r_s1_sum  <= n_sum;
        end
    end

    // stage 2: magnitude times gain for the three terms
    logic [ERR_W-1:0]  mag_e;
    logic [DIFF_W-1:0] mag_d;
    logic [SUM_W-1:0]  mag_i;

    always_comb begin
        mag_e = r_s1_err[ERR_W-1]   ? ERR_W'(-r_s1_err)   : ERR_W'(r_s1_err);
        mag_d = r_s1_diff[DIFF_W-1] ? DIFF_W'(-r_s1_diff) : DIFF_W'(r_s1_diff);
        mag_i = r_s1_sum[SUM_W-1]   ? SUM_W'(-r_s1_sum)   : SUM_W'(r_s1_sum);
    end

    always_ff @(posedge i_clk) begin
        if (rdy_2) begin
            r_s2_pe  <= 49'(mag_e) * 49'(r_kp);
            r_s2_pd  <= 50'(mag_d) * 50'(r_kd);
            r_s2_pi  <= 64'(mag_i) * 64'(r_ki);
            r_s2_ne  <= r_s1_err[ERR_W-1];
            r_s2_nd  <= r_s1_diff[DIFF_W-1];
            r_s2_ni  <= r_s1_sum[SUM_W-1];
            r_s2_err <= r_s1_err;
        end
    end

    // stage 3: limit the integral term, apply signs and add
    logic [TERM_W-1:0]        pi_lim;
    logic signed [TERM_W-1:0] t_e, t_d, t_i;

    always_comb begin
        pi_lim = (r_s2_pi > TERM_LIMIT) ? TERM_LIMIT : r_s2_pi;
        t_e    = r_s2_ne ? -signed'(TERM_W'(r_s2_pe)) : signed'(TERM_W'(r_s2_pe));
        t_d    = r_s2_nd ? -signed'(TERM_W'(r_s2_pd)) : signed'(TERM_W'(r_s2_pd));
        t_i    = r_s2_ni ? -signed'(pi_lim) : signed'(pi_lim);
    end

    always_ff @(posedge i_clk) begin
        if (rdy_3) begin
            r_s3_u   <= t_e + t_d + t_i;
            r_s3_err <= r_s2_err;
        end
    end

    // stage 4: direction, speed clamp and duty scaling
    t_dir               dir;
    logic [TERM_W-1:0]  mag_u;
    logic [39:0]        whole;
    logic [SPEED_W-1:0] ceil_v, floor_v, speed;
    logic [27:0]        duty_prod;

    always_comb begin
        priority if (r_s3_u > 0) begin
            dir = DIR_FWD;
        end else if (r_s3_u < 0) begin
            dir = DIR_BWD;
        end else begin
            dir = DIR_STOP;
        end
        mag_u   = r_s3_u[TERM_W-1] ? TERM_W'(-r_s3_u) : TERM_W'(r_s3_u);
        whole   = mag_u[TERM_W-1:FRAC_BITS];
        ceil_v  = (r_ceil > SPEED_MAX) ? SPEED_MAX : r_ceil;
        floor_v = (r_floor > SPEED_MAX) ? SPEED_MAX : r_floor;
        speed   = (whole > 40'(ceil_v)) ? ceil_v : whole[SPEED_W-1:0];
        if (speed < floor_v && r_s3_err != '0) begin
            speed = floor_v;
        end
        if (dir == DIR_STOP) begin
            speed = '0;
        end
        duty_prod = 28'(speed) * DUTY_MUL;
    end

    always_ff @(posedge i_clk) begin
        if (rdy_m) begin
            r_m_data <= {6'b0, r_s3_err, duty_prod[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT], speed, dir};
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (rdy_1) r_v1      <= i_s_tvalid;
            if (rdy_2) r_v2      <= r_v1;
            if (rdy_3) r_v3      <= r_v2;
            if (rdy_m) r_m_valid <= r_v3;
        end
    end

endmodule

`default_nettype wire

/* src/pidmpc_checker.sv */
// port level checks of the pid motor position controller and their binding
`default_nettype none

module pidmpc_checker
    import pidmpc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);

    // a stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // direction code three never shows
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != 2'd3)
        else $error("invalid direction code");

    // stop means zero speed and zero duty
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] == DIR_STOP |-> o_m_tdata[16:2] == '0)
        else $error("speed while stopped");

    // speed stays within percent range
    a_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[8:2] <= SPEED_MAX)
        else $error("speed above full scale");

    // full speed gives full duty
    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8:2] == SPEED_MAX |-> o_m_tdata[16:9] == 8'd255)
        else $error("duty scaling wrong at full speed");

endmodule

bind pid_motor_position_control pidmpc_checker u_pidmpc_checker (.*);

`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for the pid motor position controller
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pidmpc_pkg::*;

    // run bounds and pacing
    localparam int unsigned RUN_LIMIT        = 1_200_000;
    localparam int unsigned PIPE_SETTLE      = 8;
    localparam int unsigned DRAIN_LIMIT      = 4000;
    localparam int unsigned REPORT_MAX       = 10;
    localparam int unsigned RANDOM_PHASES    = 5;
    localparam int unsigned PHASE_ITEMS      = 380;
    localparam int unsigned FULL_SCALE_ITEMS = 16;

    // position and accumulator limits
    localparam int POS_TOP    = 32767;
    localparam int POS_BOTTOM = -32768;
    localparam int SUM_TOP    = 32'sh7FFF_FFFF;
    localparam int SUM_BOTTOM = 32'sh8000_0000;
    localparam int unsigned DUTY_FULL = 255;

    // register indexes the block does not decode
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        t_dir        dir;
        logic [6:0]  speed;
        logic [7:0]  duty;
        logic [16:0] err;
    } t_drive_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata   = '0;   // current_position[15:0], target_position[31:16]
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b1;
    logic [39:0] o_m_tdata;          // drive_direction[1:0], speed_percent[8:2],
                                     // pwm_duty[16:9], position_error[33:17], zero[39:34]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;

    pid_motor_position_control DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // controller shadow: registers and loop state
    logic [31:0] kp_gain, ki_gain, kd_gain;
    logic [6:0]  ceil_pct, floor_pct;
    int          prev_err, err_accum;

    t_drive_result drive_expected[$];

    int unsigned requests, results, reg_writes, failures, cycles;
    int unsigned burst_left;
    bit          idling   = 1'b1;
    bit          stalling = 1'b1;

    // free-running clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, drive_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // one gain term: signed operand times unsigned q8.24 gain, magnitude bounded
    function automatic longint scaled_term(input longint operand, input logic [31:0] gain);
        longint unsigned mag, prod;
        mag  = (operand < 0) ? -operand : operand;
        prod = mag * gain;
        if (prod > TERM_LIMIT)
            prod = TERM_LIMIT;
        return (operand < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // drive command for one control tick, advancing the shadow loop state
    function automatic t_drive_result predict_drive(input int cur, input int tgt);
        int            err;
        longint        accum;
        longint        pid_sum;
        longint unsigned whole;
        int unsigned   top, bottom, speed;
        t_drive_result r;
        err   = cur - tgt;
        accum = longint'(err_accum) + longint'(err);
        if (accum > SUM_TOP)
            accum = SUM_TOP;
        if (accum < SUM_BOTTOM)
            accum = SUM_BOTTOM;
        err_accum = int'(accum);

        pid_sum = scaled_term(err, kp_gain)
                + scaled_term(longint'(err) - longint'(prev_err), kd_gain)
                + scaled_term(err_accum, ki_gain);
        prev_err = err;

        if (pid_sum > 0)
            r.dir = DIR_FWD;
        else if (pid_sum < 0)
            r.dir = DIR_BWD;
        else
            r.dir = DIR_STOP;

        // integer part of the magnitude, then ceiling, then floor
        whole  = $unsigned((pid_sum < 0) ? -pid_sum : pid_sum) >> FRAC_BITS;
        top    = (ceil_pct > SPEED_MAX) ? 32'(SPEED_MAX) : 32'(ceil_pct);
        bottom = (floor_pct > SPEED_MAX) ? 32'(SPEED_MAX) : 32'(floor_pct);
        speed  = (whole > top) ? top : 32'(whole[6:0]);
        if (speed < bottom && err != 0)
            speed = bottom;
        if (r.dir == DIR_STOP)
            speed = 0;

        r.speed = speed[6:0];
        r.duty  = 8'(speed * DUTY_FULL / 32'(SPEED_MAX));
        r.err   = err[16:0];
        return r;
    endfunction

    // one register write request, shadowed on acceptance
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KP:    kp_gain   = value;
            CFG_KI:    ki_gain   = value;
            CFG_KD:    kd_gain   = value;
            CFG_CEIL:  ceil_pct  = value[6:0];
            CFG_FLOOR: floor_pct = value[6:0];
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // full register set; speed limits carry random upper data bits
    task automatic write_all(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kd, input logic [6:0] ceil_v,
                             input logic [6:0] floor_v);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_CEIL, {25'($urandom()), ceil_v});
        write_reg(CFG_FLOOR, {25'($urandom()), floor_v});
    endtask

    // one position request, sent in bursts with random gaps between them
    task automatic send_position(input int cur, input int tgt);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (idling)
                gap = $urandom_range(0, 6);
        end
        burst_left--;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {tgt[15:0], cur[15:0]};
        do @(posedge i_clk); while (!o_s_tready);
        drive_expected.push_back(predict_drive(cur, tgt));
        requests++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic await_idle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (drive_expected.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // receiver stall pattern: windows of random length, ready for a random part
    int unsigned rx_phase, rx_period = 4, rx_open = 2;
    always @(posedge i_clk) begin
        if (!i_rst_n || !stalling) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= (rx_phase < rx_open);
            if (rx_phase + 1 >= rx_period) begin
                rx_phase  = 0;
                rx_period = $urandom_range(1, 8);
                rx_open   = $urandom_range(1, rx_period);
                if ($urandom_range(0, 7) == 0)
                    rx_open = rx_period;
            end else begin
                rx_phase++;
            end
        end
    end

    // result checker against the oldest pending prediction
    always @(posedge i_clk) begin
        t_drive_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results++;
            if (drive_expected.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("result %0d arrived with nothing pending: tdata %h",
                             results, o_m_tdata);
            end else begin
                want = drive_expected.pop_front();
                if (o_m_tdata[1:0] !== want.dir || o_m_tdata[8:2] !== want.speed ||
                    o_m_tdata[16:9] !== want.duty || o_m_tdata[33:17] !== want.err ||
                    o_m_tdata[39:34] !== '0) begin
                    failures++;
                    if (failures <= REPORT_MAX) begin
                        $display("result %0d: expected dir %0d speed %0d duty %0d err %0d",
                                 results, want.dir, want.speed, want.duty,
                                 $signed(want.err));
                        $display("    got dir %0d speed %0d duty %0d err %0d pad %0h",
                                 o_m_tdata[1:0], o_m_tdata[8:2], o_m_tdata[16:9],
                                 $signed(o_m_tdata[33:17]), o_m_tdata[39:34]);
                    end
                end
            end
        end
    end

    // random gain: zero, full scale, any value or a realistic one
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            3:       return $urandom_range(0, 32'h0400_0000);
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    // random speed limit, including values above the 100 percent cap
    function automatic logic [6:0] pick_pct();
        case ($urandom_range(0, 4))
            0:       return 7'd0;
            1:       return SPEED_MAX;
            2:       return 7'h7F;
            3:       return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(0, 100));
        endcase
    endfunction

    // random tick: close to target most often, else wide swings and corners
    task automatic send_random_position();
        int cur, tgt;
        int corners[7] = '{POS_BOTTOM, POS_BOTTOM + 1, -1, 0, 1, POS_TOP - 1, POS_TOP};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                tgt = int'($urandom_range(0, 65535)) - 32768;
                cur = tgt + int'($urandom_range(0, 600)) - 300;
                if (cur > POS_TOP)
                    cur = POS_TOP;
                if (cur < POS_BOTTOM)
                    cur = POS_BOTTOM;
            end
            4, 5, 6: begin
                cur = int'($urandom_range(0, 65535)) - 32768;
                tgt = int'($urandom_range(0, 65535)) - 32768;
            end
            default: begin
                cur = corners[$urandom_range(0, 6)];
                tgt = corners[$urandom_range(0, 6)];
            end
        endcase
        send_position(cur, tgt);
    endtask

    // default gains straight out of reset, zero and extreme errors
    task automatic test_default_gains();
        send_position(0, 0);
        send_position(100, 0);
        send_position(100, 100);   // zero error: the integral and derivative terms remain
        send_position(POS_TOP, POS_BOTTOM);
        send_position(POS_BOTTOM, POS_TOP);
        send_position(-1, 0);
        send_position(0, -1);
        send_position(POS_BOTTOM, POS_BOTTOM);
    endtask

    // speed ceiling and floor, values above 100 and floor above ceiling
    task automatic test_speed_limits();
        await_idle();
        write_reg(CFG_CEIL, 32'(SPEED_MAX));
        write_reg(CFG_FLOOR, 32'd0);
        send_position(200, 0);
        send_position(0, 200);
        await_idle();
        write_reg(CFG_CEIL, 32'hFFFF_FFFF);
        write_reg(CFG_FLOOR, 32'h0000_007F);
        send_position(5, 0);
        send_position(0, 0);
        await_idle();
        write_reg(CFG_CEIL, 32'd20);
        write_reg(CFG_FLOOR, 32'd60);
        send_position(3, 0);
        send_position(500, 0);
        await_idle();
        write_reg(CFG_CEIL, 32'd0);
        write_reg(CFG_FLOOR, 32'd0);
        send_position(1000, 0);
        send_position(-1000, 0);
    endtask

    // all gains zero gives stop despite an error; then all gains at full scale
    task automatic test_gain_extremes();
        await_idle();
        write_all(32'd0, 32'd0, 32'd0, RST_CEIL, RST_FLOOR);
        send_position(123, -45);
        send_position(POS_BOTTOM, POS_TOP);
        await_idle();
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SPEED_MAX, 7'd1);
        send_position(POS_TOP, POS_BOTTOM);
        send_position(POS_BOTTOM, POS_TOP);
    endtask

    // writes to undecoded indexes must leave every register alone
    task automatic test_spare_indexes();
        await_idle();
        for (int i = CFG_SPARE_LO; i <= CFG_SPARE_HI; i++)
            write_reg(3'(i), $urandom());
        send_position(10, 0);
        send_position(-10, 0);
    endtask

    // random ticks over several register settings, one phase without idling or stalls
    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            await_idle();
            write_all(pick_gain(), pick_gain(), pick_gain(), pick_pct(), pick_pct());
            idling   = (p != 1);
            stalling = (p != 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_position();
        end
        idling   = 1'b1;
        stalling = 1'b1;
    endtask

    // full-scale errors back to back with no gaps or stalls, one way then the other, then random ticks
    task automatic test_full_scale_run();
        await_idle();
        idling   = 1'b0;
        stalling = 1'b0;
        write_all(32'd0, 32'hFFFF_FFFF, 32'd0, SPEED_MAX, 7'd0);
        for (int n = 0; n < FULL_SCALE_ITEMS; n++)
            send_position(POS_TOP, POS_BOTTOM);
        for (int n = 0; n < 2 * FULL_SCALE_ITEMS; n++)
            send_position(POS_BOTTOM, POS_TOP);
        idling   = 1'b1;
        stalling = 1'b1;
        for (int n = 0; n < 8; n++)
            send_random_position();
    endtask

    // test sequence
    initial begin
        int unsigned waited;
        kp_gain   = RST_KP;
        ki_gain   = RST_KI;
        kd_gain   = RST_KD;
        ceil_pct  = RST_CEIL;
        floor_pct = RST_FLOOR;
        prev_err  = 0;
        err_accum = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_gains();
        test_speed_limits();
        test_gain_extremes();
        test_spare_indexes();
        test_random_traffic();
        test_full_scale_run();

        // drain, then allow for the pipeline to empty
        i_s_tvalid <= 1'b0;
        waited = 0;
        while (drive_expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (drive_expected.size() != 0) begin
            failures += drive_expected.size();
            $display("%0d predicted results never arrived", drive_expected.size());
        end

        $display("%0d position requests, %0d drive results, %0d register writes",
                 requests, results, reg_writes);
        $display("covered default, zero and full-scale gains, speed limits, spare indexes,");
        $display("bursty and stalled traffic and full-scale error runs; %0d failures",
                 failures);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
